// ===== rtl/core/spim_pkg.sv =====
// Package for the three-wire half-duplex SPI master.
// Holds the command and mode codes, the field widths and the item types.
// No dependencies.
`timescale 1ns / 1ps

package spim_pkg;

    localparam int WORD_BITS   = 8;
    localparam int COUNT_WIDTH = 16;
    localparam int BITS_W      = $clog2(WORD_BITS + 1);

    localparam logic [COUNT_WIDTH-1:0] HALF_RESET = COUNT_WIDTH'(240);

    // Opcodes on the input port
    localparam logic [2:0] OP_NONE     = 3'd0;
    localparam logic [2:0] OP_SELECT   = 3'd1;
    localparam logic [2:0] OP_DESELECT = 3'd2;
    localparam logic [2:0] OP_WRITE    = 3'd3;
    localparam logic [2:0] OP_READ     = 3'd4;

    // Command classes after decoding
    localparam logic [2:0] CMD_NONE     = 3'd0;
    localparam logic [2:0] CMD_SELECT   = 3'd1;
    localparam logic [2:0] CMD_DESELECT = 3'd2;
    localparam logic [2:0] CMD_WRITE    = 3'd3;
    localparam logic [2:0] CMD_READ     = 3'd4;

    // Transfer modes of the engine
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    typedef struct packed {
        logic [2:0]           cmd;
        logic [WORD_BITS-1:0] wbyte;
        logic                 din;
    } t_cmd_item;

    typedef struct packed {
        logic                 sclk;
        logic                 cs_n;
        logic                 data_out;
        logic                 data_oe;
        logic                 busy;
        logic                 read_done;
        logic [WORD_BITS-1:0] read_data;
    } t_result;

endpackage

// ===== rtl/core/spim_front.sv =====
// Front stage of the SPI master: accepts input transactions and decodes the opcode.
// Depends on spim_pkg.
`timescale 1ns / 1ps

module spim_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [2:0]                   i_opcode,
    input  logic [spim_pkg::WORD_BITS-1:0] i_write_byte,
    input  logic                         i_data_in,
    output spim_pkg::t_cmd_item          o_item,
    output logic                         o_valid,
    input  logic                         i_ready
);

    logic                r_valid, n_valid;
    spim_pkg::t_cmd_item r_item, n_item;
    logic                accept;
    logic [2:0]          cmd_class;

    always_comb begin
        case (i_opcode)
            spim_pkg::OP_SELECT:   cmd_class = spim_pkg::CMD_SELECT;
            spim_pkg::OP_DESELECT: cmd_class = spim_pkg::CMD_DESELECT;
            spim_pkg::OP_WRITE:    cmd_class = spim_pkg::CMD_WRITE;
            spim_pkg::OP_READ:     cmd_class = spim_pkg::CMD_READ;
            default:               cmd_class = spim_pkg::CMD_NONE;
        endcase
    end

    assign full   = r_valid && !i_ready;
    assign accept = push && !full;

    always_comb begin
        n_valid = r_valid;
        n_item  = r_item;
        if (accept) begin
            n_valid      = 1'b1;
            n_item.cmd   = cmd_class;
            n_item.wbyte = i_write_byte;
            n_item.din   = i_data_in;
        end else if (r_valid && i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_item <= n_item;
    end

    assign o_item  = r_item;
    assign o_valid = r_valid;

endmodule

// ===== rtl/core/spim_cmd_queue.sv =====
// Four-entry queue of decoded commands between the front stage and the engine.
// Depends on spim_pkg.
`timescale 1ns / 1ps

module spim_cmd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  spim_pkg::t_cmd_item i_item,
    input  logic                i_push,
    output logic                o_ready,
    output spim_pkg::t_cmd_item o_item,
    output logic                o_valid,
    input  logic                i_pop
);

    localparam int DEPTH = 4;

    spim_pkg::t_cmd_item r_mem [DEPTH];
    logic [1:0] r_wr_ptr, n_wr_ptr;
    logic [1:0] r_rd_ptr, n_rd_ptr;
    logic [2:0] r_count, n_count;
    logic       do_push, do_pop;

    assign o_ready = (r_count < 3'(DEPTH));
    assign o_valid = (r_count != 3'd0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 2'd1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 2'd1 : r_rd_ptr;
        n_count  = r_count + 3'(do_push) - 3'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== rtl/core/spim_engine.sv =====
// Bit timing engine of the SPI master: runs one tick per command and builds the result.
// Holds the half period register. Depends on spim_pkg.
`timescale 1ns / 1ps

module spim_engine (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [spim_pkg::COUNT_WIDTH-1:0]    i_cfg_data,
    input  spim_pkg::t_cmd_item                 i_item,
    input  logic                                i_valid,
    output logic                                o_take,
    output spim_pkg::t_result                   o_res,
    input  logic                                i_res_ready
);

    logic [spim_pkg::COUNT_WIDTH-1:0] r_half;
    logic [spim_pkg::COUNT_WIDTH-1:0] r_tick, n_tick;
    logic [spim_pkg::BITS_W-1:0]      r_bits, n_bits;
    logic [spim_pkg::WORD_BITS-1:0]   r_shift, n_shift;
    logic [1:0]                       r_mode, n_mode;
    logic r_high, n_high;
    logic r_sclk, n_sclk;
    logic r_sel, n_sel;
    logic r_dval, n_dval;
    logic r_doe, n_doe;

    logic [spim_pkg::COUNT_WIDTH-1:0] half_eff;
    logic [spim_pkg::BITS_W-1:0]      bits_dec;
    logic [spim_pkg::WORD_BITS-1:0]   shifted;
    logic done;
    logic [spim_pkg::WORD_BITS-1:0]   rdata;

    assign o_take   = i_valid && i_res_ready;
    assign half_eff = (r_half == '0) ? spim_pkg::COUNT_WIDTH'(1) : r_half;
    assign bits_dec = (r_bits != '0) ? r_bits - spim_pkg::BITS_W'(1) : r_bits;
    assign shifted  = {r_shift[spim_pkg::WORD_BITS-2:0], 1'b0};

    always_comb begin
        n_tick  = r_tick;
        n_bits  = r_bits;
        n_shift = r_shift;
        n_mode  = r_mode;
        n_high  = r_high;
        n_sclk  = r_sclk;
        n_sel   = r_sel;
        n_dval  = r_dval;
        n_doe   = r_doe;
        done    = 1'b0;
        rdata   = '0;

        if (r_mode == spim_pkg::MODE_IDLE) begin
            case (i_item.cmd)
                spim_pkg::CMD_SELECT: begin
                    n_sel = 1'b0;
                end
                spim_pkg::CMD_DESELECT: begin
                    n_sel = 1'b1;
                end
                spim_pkg::CMD_WRITE: begin
                    n_mode  = spim_pkg::MODE_WRITE;
                    n_doe   = 1'b1;
                    n_shift = i_item.wbyte;
                    n_bits  = spim_pkg::BITS_W'(spim_pkg::WORD_BITS);
                    n_sclk  = 1'b0;
                    n_high  = 1'b0;
                    n_tick  = spim_pkg::COUNT_WIDTH'(1);
                    n_dval  = i_item.wbyte[spim_pkg::WORD_BITS-1];
                end
                spim_pkg::CMD_READ: begin
                    n_mode  = spim_pkg::MODE_READ;
                    n_doe   = 1'b0;
                    n_shift = '0;
                    n_bits  = spim_pkg::BITS_W'(spim_pkg::WORD_BITS);
                    n_sclk  = 1'b0;
                    n_high  = 1'b0;
                    n_tick  = spim_pkg::COUNT_WIDTH'(1);
                end
                default: begin
                end
            endcase
        end else if (r_tick < half_eff) begin
            n_tick = r_tick + spim_pkg::COUNT_WIDTH'(1);
        end else if (!r_high) begin
            // Rising edge of the serial clock: the read samples the pin here
            n_sclk = 1'b1;
            n_high = 1'b1;
            n_tick = spim_pkg::COUNT_WIDTH'(1);
            if (r_mode == spim_pkg::MODE_READ) begin
                n_shift = {r_shift[spim_pkg::WORD_BITS-2:0], i_item.din};
            end
        end else begin
            if (r_mode == spim_pkg::MODE_WRITE) begin
                n_shift = shifted;
            end
            n_bits = bits_dec;
            if (bits_dec == '0) begin
                if (r_mode == spim_pkg::MODE_READ) begin
                    done  = 1'b1;
                    rdata = r_shift;
                end
                n_mode = spim_pkg::MODE_IDLE;
                n_high = 1'b0;
                n_tick = '0;
            end else begin
                n_sclk = 1'b0;
                n_high = 1'b0;
                n_tick = spim_pkg::COUNT_WIDTH'(1);
                if (r_mode == spim_pkg::MODE_WRITE) begin
                    n_dval = shifted[spim_pkg::WORD_BITS-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half  <= spim_pkg::HALF_RESET;
            r_tick  <= '0;
            r_bits  <= '0;
            r_shift <= '0;
            r_mode  <= spim_pkg::MODE_IDLE;
            r_high  <= 1'b0;
            r_sclk  <= 1'b1;
            r_sel   <= 1'b1;
            r_dval  <= 1'b0;
            r_doe   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_half <= i_cfg_data;
            end
            if (o_take) begin
                r_tick  <= n_tick;
                r_bits  <= n_bits;
                r_shift <= n_shift;
                r_mode  <= n_mode;
                r_high  <= n_high;
                r_sclk  <= n_sclk;
                r_sel   <= n_sel;
                r_dval  <= n_dval;
                r_doe   <= n_doe;
            end
        end
    end

    always_comb begin
        o_res.sclk      = n_sclk;
        o_res.cs_n      = n_sel;
        o_res.data_out  = n_dval;
        o_res.data_oe   = n_doe;
        o_res.busy      = (n_mode != spim_pkg::MODE_IDLE);
        o_res.read_done = done;
        o_res.read_data = rdata;
    end

endmodule

// ===== rtl/core/spim_res_queue.sv =====
// Two-entry result queue that parts the engine from the consumer of results.
// Depends on spim_pkg.
`timescale 1ns / 1ps

module spim_res_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spim_pkg::t_result i_res,
    input  logic              i_push,
    output logic              o_ready,
    output spim_pkg::t_result o_res,
    output logic              empty,
    input  logic              pop
);

    localparam int DEPTH = 2;

    spim_pkg::t_result r_mem [DEPTH];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       do_push, do_pop;

    assign o_ready = (r_count < 2'(DEPTH));
    assign empty   = (r_count == 2'd0);
    assign o_res   = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = pop && !empty;

    always_comb begin
        n_wr_ptr = do_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_res;
        end
    end

endmodule

// ===== rtl/core/spi_half_duplex_master.sv =====
// Top level of the three-wire half-duplex SPI master (mode 3, MSB first).
// Instantiates spim_front, spim_cmd_queue, spim_engine and spim_res_queue; uses spim_pkg.
`timescale 1ns / 1ps

// Each input transaction is one tick of the bit timing and yields exactly one result
// transaction with the pin levels after that tick. The block takes one transaction per
// clock cycle sustained while results are popped and no queue fills; that rate is set by
// the engine, which advances its tick counter and bit state once per transaction. An input
// is held in the front stage register and then the command queue, and its result in the
// result queue before it reaches the result ports. The half period register may be written
// only while no transaction is in flight; a value of zero behaves as one.

module spi_half_duplex_master (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [spim_pkg::COUNT_WIDTH-1:0]   i_cfg_wdata,
    input  logic                               push,
    output logic                               full,
    input  logic [2:0]                         i_opcode,
    input  logic [spim_pkg::WORD_BITS-1:0]     i_write_byte,
    input  logic                               i_data_in,
    output logic                               empty,
    input  logic                               pop,
    output logic                               o_sclk,
    output logic                               o_cs_n,
    output logic                               o_data_out,
    output logic                               o_data_oe,
    output logic                               o_busy_res,
    output logic                               o_read_done,
    output logic [spim_pkg::WORD_BITS-1:0]     o_read_data
);

    spim_pkg::t_cmd_item front_item, queue_item;
    spim_pkg::t_result   eng_res, out_res;
    logic front_valid, cmdq_ready, cmdq_valid, eng_take, resq_ready;

    spim_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_opcode     (i_opcode),
        .i_write_byte (i_write_byte),
        .i_data_in    (i_data_in),
        .o_item       (front_item),
        .o_valid      (front_valid),
        .i_ready      (cmdq_ready)
    );

    spim_cmd_queue u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (front_item),
        .i_push  (front_valid),
        .o_ready (cmdq_ready),
        .o_item  (queue_item),
        .o_valid (cmdq_valid),
        .i_pop   (eng_take)
    );

    spim_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_wdata),
        .i_item      (queue_item),
        .i_valid     (cmdq_valid),
        .o_take      (eng_take),
        .o_res       (eng_res),
        .i_res_ready (resq_ready)
    );

    spim_res_queue u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (eng_res),
        .i_push  (eng_take),
        .o_ready (resq_ready),
        .o_res   (out_res),
        .empty   (empty),
        .pop     (pop)
    );

    assign o_sclk      = out_res.sclk;
    assign o_cs_n      = out_res.cs_n;
    assign o_data_out  = out_res.data_out;
    assign o_data_oe   = out_res.data_oe;
    assign o_busy_res  = out_res.busy;
    assign o_read_done = out_res.read_done;
    assign o_read_data = out_res.read_data;

    // A completed read leaves the engine idle with the driver released.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_read_done) |-> (!o_busy_res && !o_data_oe && o_sclk))
        else $error("read completion with engine still busy or driving");

    // Received data is only shown in the transaction that completes a read.
    a_rdata_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_read_done) |-> (o_read_data == '0))
        else $error("read data non-zero outside read completion");

    // The engine never takes a command that the result queue cannot hold.
    a_take_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_take |-> (cmdq_valid && resq_ready))
        else $error("engine advanced without a command or result space");

endmodule
